// ===== hdl/scrv_pkg.sv =====
// ----------------------------------------------------------------------------
// scrv_pkg
// shared constants and widths for the sphere radius vote block
// ----------------------------------------------------------------------------
package scrv_pkg;

    localparam int DEF_MAX_POINTS = 4096;
    localparam int DEF_MAX_BINS   = 64;

    localparam int COORD_W  = 24;
    localparam int SCALE_W  = 24;
    localparam int WEIGHT_W = 21;
    localparam int MUL_W    = 25;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int SQ_IN_W  = 50;
    localparam int SQ_OUT_W = SQ_IN_W / 2;

    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = '1;
    localparam logic [8:0]          VOTE_ONE   = 9'd256;

    localparam logic [1:0] OP_LOAD     = 2'd0;
    localparam logic [1:0] OP_QUERY    = 2'd1;
    localparam logic [1:0] OP_CLEAR    = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    localparam logic [1:0] REG_BIN_COUNT = 2'd0;
    localparam logic [1:0] REG_SCALE     = 2'd1;
    localparam logic [1:0] REG_BIN_WIDTH = 2'd2;

endpackage

// ===== hdl/scrv_isqrt.sv =====
// ----------------------------------------------------------------------------
// scrv_isqrt
// iterative integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module scrv_isqrt
    import scrv_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [SQ_IN_W-1:0]  radicand,
    output logic                done,
    output logic [SQ_OUT_W-1:0] root
);

    localparam int CNT_W = $clog2(SQ_OUT_W + 1);

    logic [SQ_IN_W-1:0]  val_reg;
    logic [27:0]         rem_reg;
    logic [SQ_OUT_W-1:0] root_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [29:0] rem_t;
    logic [29:0] trial;
    logic        ge;

    assign rem_t = {rem_reg, val_reg[SQ_IN_W-1 -: 2]};
    assign trial = {3'b000, root_reg, 2'b01};
    assign ge    = (rem_t >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SQ_OUT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            val_reg  <= {val_reg[SQ_IN_W-3:0], 2'b00};
            rem_reg  <= ge ? 28'(rem_t - trial) : rem_t[27:0];
            root_reg <= {root_reg[SQ_OUT_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("root done without a running iteration");
`endif

endmodule

// ===== hdl/sphere_center_radius_vote.sv =====
// ----------------------------------------------------------------------------
// sphere_center_radius_vote
// radius histogram vote of stored surface points around a query voxel
// ----------------------------------------------------------------------------
// input channel: in_valid/in_stall carry op and coord_x/y/z. a load
// transaction writes one point while the store has room, a clear empties
// the store. a query clears all MAX_BINS histogram entries, then walks every
// stored point (three squares on the shared multiplier, a bit-serial square
// root, the scale multiply and two histogram read-modify-writes), then
// scans the bins in use and multiplies out the radius.
// in_stall stays high while a query runs.
// output channel: out_valid/out_stall carry one transaction per query from
// an output register; a stalled result holds and the block waits to finish
// until the register is free.
// config channel: cfg_valid/cfg_ready, always ready. the user must write
// it only while idle; the block itself does not enforce this.
// reset empties the point store and sets registers to 32 bins, scale 1.0,
// bin width 1.0. no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module sphere_center_radius_vote
    import scrv_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int MAX_BINS   = DEF_MAX_BINS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              op,
    input  logic signed [COORD_W-1:0] coord_x,
    input  logic signed [COORD_W-1:0] coord_y,
    input  logic signed [COORD_W-1:0] coord_z,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [WEIGHT_W-1:0]     peak_weight,
    output logic [23:0]             peak_radius,
    output logic                    points_dropped,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [1:0]              cfg_index,
    input  logic [23:0]             cfg_data
);

    localparam int PIW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int PCW = $clog2(MAX_POINTS + 1);
    localparam int BIW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int BCW = $clog2(MAX_BINS + 1);

    typedef enum logic [4:0] {
        ST_IDLE, ST_CLR, ST_PRD, ST_MX, ST_MY, ST_MZ, ST_MACC, ST_SQ, ST_SQW,
        ST_MSC, ST_HRD0, ST_HWR0, ST_HRD1, ST_HWR1, ST_SRD, ST_SCMP, ST_MRAD,
        ST_RES
    } state_t;

    state_t state_reg;

    // configuration
    logic [6:0]         bin_count_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [SCALE_W-1:0] bin_width_reg;

    logic [PCW-1:0] total_reg;
    logic           overflow_reg;

    logic [COORD_W-1:0] mem_x [MAX_POINTS];
    logic [COORD_W-1:0] mem_y [MAX_POINTS];
    logic [COORD_W-1:0] mem_z [MAX_POINTS];
    logic [WEIGHT_W-1:0] hist [MAX_BINS];

    logic [COORD_W-1:0] px_reg, py_reg, pz_reg;
    logic [COORD_W-1:0] qx_reg, qy_reg, qz_reg;
    logic [WEIGHT_W-1:0] hq_reg;

    logic [BCW-1:0]      nb_reg;
    logic [BCW-1:0]      hc_reg;
    logic [PCW-1:0]      pidx_reg;
    logic [BCW-1:0]      sidx_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [SQ_IN_W-1:0]  acc_reg;
    logic [SQ_OUT_W-1:0] dist_reg;
    logic [26:0]         vidx_reg;
    logic [7:0]          f_reg;
    logic [WEIGHT_W-1:0] best_reg;
    logic [BIW-1:0]      bidx_reg;

    logic                    out_valid_reg;
    logic [WEIGHT_W-1:0]     peak_weight_reg;
    logic [23:0]             peak_radius_reg;
    logic                    dropped_reg;

    logic in_accept;
    logic out_free;
    logic [BCW-1:0] nb_next;

    logic signed [COORD_W:0] dx, dy, dz, dsel;
    logic [MUL_W-1:0] mag;
    logic [MUL_W-1:0] mul_a, mul_b;
    logic [PROD_W-1:0] mul_p;

    logic            sq_done;
    logic [SQ_OUT_W-1:0] sq_root;

    logic [BIW-1:0]      h_raddr;
    logic                h_we;
    logic [BIW-1:0]      h_waddr;
    logic [WEIGHT_W-1:0] h_wdata;
    logic [WEIGHT_W:0]   h_sum;
    logic [8:0]          vote_w;
    logic                vote_in_range;
    logic [26:0]         d0;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;

    assign nb_next = ({25'd0, bin_count_reg} > 32'(MAX_BINS)) ? BCW'(MAX_BINS)
                                                              : BCW'(bin_count_reg);

    // shared multiplier operand select
    assign dx = {px_reg[COORD_W-1], px_reg} - {qx_reg[COORD_W-1], qx_reg};
    assign dy = {py_reg[COORD_W-1], py_reg} - {qy_reg[COORD_W-1], qy_reg};
    assign dz = {pz_reg[COORD_W-1], pz_reg} - {qz_reg[COORD_W-1], qz_reg};

    always_comb
    begin
        case (state_reg)
            ST_MY:   dsel = dy;
            ST_MZ:   dsel = dz;
            default: dsel = dx;
        endcase
        mag = dsel[COORD_W] ? MUL_W'(-dsel) : MUL_W'(dsel);
        case (state_reg)
            ST_MSC:
            begin
                mul_a = dist_reg;
                mul_b = {1'b0, scale_reg};
            end
            ST_MRAD:
            begin
                mul_a = MUL_W'(bidx_reg);
                mul_b = {1'b0, bin_width_reg};
            end
            default:
            begin
                mul_a = mag;
                mul_b = mag;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    scrv_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_SQ),
        .radicand (acc_reg),
        .done     (sq_done),
        .root     (sq_root)
    );

    // histogram read-modify-write
    assign d0     = {1'b0, prod_reg[PROD_W-1:24]};
    assign vote_w = (state_reg == ST_HWR0) ? (VOTE_ONE - {1'b0, f_reg}) : {1'b0, f_reg};
    assign h_sum  = {1'b0, hq_reg} + (WEIGHT_W + 1)'(vote_w);
    assign vote_in_range = (vidx_reg < 27'(nb_reg));

    always_comb
    begin
        case (state_reg)
            ST_HRD0: h_raddr = d0[BIW-1:0];
            // vidx_reg already points at the upper bin here
            ST_HRD1: h_raddr = vidx_reg[BIW-1:0];
            default: h_raddr = sidx_reg[BIW-1:0];
        endcase
        h_we    = 1'b0;
        h_waddr = vidx_reg[BIW-1:0];
        h_wdata = h_sum[WEIGHT_W] ? WEIGHT_MAX : h_sum[WEIGHT_W-1:0];
        case (state_reg)
            ST_CLR:
            begin
                h_we    = 1'b1;
                h_waddr = hc_reg[BIW-1:0];
                h_wdata = '0;
            end
            ST_HWR0, ST_HWR1: h_we = vote_in_range;
            default: h_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (h_we)
            hist[h_waddr] <= h_wdata;
        hq_reg <= hist[h_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && op == OP_LOAD && total_reg < PCW'(MAX_POINTS))
        begin
            mem_x[total_reg[PIW-1:0]] <= coord_x;
            mem_y[total_reg[PIW-1:0]] <= coord_y;
            mem_z[total_reg[PIW-1:0]] <= coord_z;
        end
        px_reg <= mem_x[pidx_reg[PIW-1:0]];
        py_reg <= mem_y[pidx_reg[PIW-1:0]];
        pz_reg <= mem_z[pidx_reg[PIW-1:0]];
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                qx_reg <= coord_x;
                qy_reg <= coord_y;
                qz_reg <= coord_z;
            end
            ST_MX:   prod_reg <= mul_p;
            ST_MY:
            begin
                prod_reg <= mul_p;
                acc_reg  <= prod_reg;
            end
            ST_MZ:
            begin
                prod_reg <= mul_p;
                acc_reg  <= acc_reg + prod_reg;
            end
            ST_MACC: acc_reg  <= acc_reg + prod_reg;
            ST_SQW:  dist_reg <= sq_root;
            ST_MSC:  prod_reg <= mul_p;
            ST_HRD0:
            begin
                vidx_reg <= d0;
                f_reg    <= prod_reg[23:16];
            end
            ST_HWR0: vidx_reg <= vidx_reg + 27'd1;
            ST_MRAD: prod_reg <= mul_p;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            bin_count_reg   <= 7'd32;
            scale_reg       <= 24'd65536;
            bin_width_reg   <= 24'd65536;
            total_reg       <= '0;
            overflow_reg    <= 1'b0;
            nb_reg          <= '0;
            hc_reg          <= '0;
            pidx_reg        <= '0;
            sidx_reg        <= '0;
            best_reg        <= '0;
            bidx_reg        <= '0;
            out_valid_reg   <= 1'b0;
            peak_weight_reg <= '0;
            peak_radius_reg <= '0;
            dropped_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_BIN_COUNT: bin_count_reg <= cfg_data[6:0];
                    REG_SCALE:     scale_reg     <= cfg_data;
                    REG_BIN_WIDTH: bin_width_reg <= cfg_data;
                    default: ;
                endcase
            end
            // the result state refills the register itself
            if (out_valid_reg && !out_stall && state_reg != ST_RES)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        case (op)
                            OP_LOAD:
                            begin
                                if (total_reg < PCW'(MAX_POINTS))
                                    total_reg <= total_reg + 1'b1;
                                else
                                    overflow_reg <= 1'b1;
                            end
                            OP_CLEAR:
                            begin
                                total_reg    <= '0;
                                overflow_reg <= 1'b0;
                            end
                            OP_QUERY:
                            begin
                                nb_reg    <= nb_next;
                                hc_reg    <= '0;
                                pidx_reg  <= '0;
                                sidx_reg  <= '0;
                                best_reg  <= '0;
                                bidx_reg  <= '0;
                                state_reg <= ST_CLR;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_CLR:
                begin
                    hc_reg <= hc_reg + 1'b1;
                    if (hc_reg == BCW'(MAX_BINS - 1))
                    begin
                        if (total_reg != '0)
                            state_reg <= ST_PRD;
                        else if (nb_reg != '0)
                            state_reg <= ST_SRD;
                        else
                            state_reg <= ST_MRAD;
                    end
                end
                ST_PRD:  state_reg <= ST_MX;
                ST_MX:   state_reg <= ST_MY;
                ST_MY:   state_reg <= ST_MZ;
                ST_MZ:   state_reg <= ST_MACC;
                ST_MACC: state_reg <= ST_SQ;
                ST_SQ:   state_reg <= ST_SQW;
                ST_SQW:
                begin
                    if (sq_done)
                        state_reg <= ST_MSC;
                end
                ST_MSC:  state_reg <= ST_HRD0;
                ST_HRD0: state_reg <= ST_HWR0;
                ST_HWR0: state_reg <= ST_HRD1;
                ST_HRD1: state_reg <= ST_HWR1;
                ST_HWR1:
                begin
                    pidx_reg <= pidx_reg + 1'b1;
                    if (pidx_reg + 1'b1 == total_reg)
                        state_reg <= (nb_reg != '0) ? ST_SRD : ST_MRAD;
                    else
                        state_reg <= ST_PRD;
                end
                ST_SRD:  state_reg <= ST_SCMP;
                ST_SCMP:
                begin
                    if (hq_reg > best_reg)
                    begin
                        best_reg <= hq_reg;
                        bidx_reg <= sidx_reg[BIW-1:0];
                    end
                    sidx_reg <= sidx_reg + 1'b1;
                    state_reg <= (sidx_reg + 1'b1 == nb_reg) ? ST_MRAD : ST_SRD;
                end
                ST_MRAD: state_reg <= ST_RES;
                ST_RES:
                begin
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        peak_weight_reg <= best_reg;
                        peak_radius_reg <= (prod_reg[PROD_W-1:24] != '0) ? 24'hFFFFFF
                                                                         : prod_reg[23:0];
                        dropped_reg     <= overflow_reg;
                        state_reg       <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign peak_weight    = peak_weight_reg;
    assign peak_radius    = peak_radius_reg;
    assign points_dropped = dropped_reg;

`ifndef SYNTHESIS
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= PCW'(MAX_POINTS))
        else $error("point count beyond store capacity");
    a_result_from_res: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_RES))
        else $error("result raised outside result state");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> $stable(peak_weight_reg)
                                         && $stable(peak_radius_reg))
        else $error("stalled result overwritten");
    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PRD) |-> (pidx_reg < total_reg))
        else $error("point walk beyond stored points");
`endif

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// checks the sphere radius vote block: loads, clears and queries are sent
// with random gaps and stalls, and every query result is compared with a
// bit-exact prediction
// ----------------------------------------------------------------------------

class vote_scoreboard;
    typedef struct {
        logic [20:0] weight;
        logic [23:0] radius;
        logic        dropped;
    } vote_peak_t;

    logic [23:0] pts_x[scrv_pkg::DEF_MAX_POINTS];
    logic [23:0] pts_y[scrv_pkg::DEF_MAX_POINTS];
    logic [23:0] pts_z[scrv_pkg::DEF_MAX_POINTS];
    int unsigned n_pts;
    bit          dropped_flag;
    logic [6:0]  bins_cfg;
    logic [23:0] scale_cfg;
    logic [23:0] width_cfg;
    vote_peak_t  peaks_due[$];
    int          errors;

    function new();
        n_pts = 0;
        dropped_flag = 0;
        bins_cfg = 7'd32;
        scale_cfg = 24'd65536;
        width_cfg = 24'd65536;
        errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [23:0] data);
        case (idx)
            scrv_pkg::REG_BIN_COUNT: bins_cfg = data[6:0];
            scrv_pkg::REG_SCALE:     scale_cfg = data;
            scrv_pkg::REG_BIN_WIDTH: width_cfg = data;
            default: ;
        endcase
    endfunction

    function longint unsigned int_root(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function longint unsigned sq_delta(logic [23:0] a, logic [23:0] b);
        longint d;
        d = longint'($signed(a)) - longint'($signed(b));
        if (d < 0)
            d = -d;
        return longint'(d) * longint'(d);
    endfunction

    function vote_peak_t peak_of_query(logic [23:0] x, logic [23:0] y, logic [23:0] z);
        int unsigned hist[64];
        int unsigned nb;
        int unsigned best;
        int unsigned best_idx;
        longint unsigned s2;
        longint unsigned pos;
        longint unsigned d0;
        longint unsigned rad;
        int unsigned f;
        vote_peak_t p;
        nb = (bins_cfg > 64) ? 64 : bins_cfg;
        foreach (hist[i])
            hist[i] = 0;
        for (int unsigned i = 0; i < n_pts; i++)
        begin
            s2 = sq_delta(pts_x[i], x) + sq_delta(pts_y[i], y) + sq_delta(pts_z[i], z);
            pos = int_root(s2) * longint'(scale_cfg);
            d0 = pos >> 24;
            f = (pos >> 16) & 64'hFF;
            if (d0 < nb)
                hist[d0] = (hist[d0] + 256 - f > 32'h1FFFFF) ? 32'h1FFFFF
                                                             : hist[d0] + 256 - f;
            if (d0 + 1 < nb)
                hist[d0 + 1] = (hist[d0 + 1] + f > 32'h1FFFFF) ? 32'h1FFFFF
                                                               : hist[d0 + 1] + f;
        end
        best = 0;
        best_idx = 0;
        for (int unsigned i = 0; i < nb; i++)
            if (hist[i] > best)
            begin
                best = hist[i];
                best_idx = i;
            end
        rad = longint'(best_idx) * longint'(width_cfg);
        if (rad > 64'hFFFFFF)
            rad = 64'hFFFFFF;
        p.weight = best[20:0];
        p.radius = rad[23:0];
        p.dropped = dropped_flag;
        return p;
    endfunction

    function void note_input(logic [1:0] o, logic [23:0] x, logic [23:0] y, logic [23:0] z);
        case (o)
            scrv_pkg::OP_LOAD:
                if (n_pts < scrv_pkg::DEF_MAX_POINTS)
                begin
                    pts_x[n_pts] = x;
                    pts_y[n_pts] = y;
                    pts_z[n_pts] = z;
                    n_pts++;
                end
                else
                    dropped_flag = 1;
            scrv_pkg::OP_CLEAR:
            begin
                n_pts = 0;
                dropped_flag = 0;
            end
            scrv_pkg::OP_QUERY: peaks_due.push_back(peak_of_query(x, y, z));
            default: ;
        endcase
    endfunction

    function void check_result(logic [20:0] w, logic [23:0] r, logic d, time t);
        vote_peak_t e;
        if (peaks_due.size() == 0)
        begin
            $display("%0t: unexpected result weight %0d radius %0d", t, w, r);
            errors++;
            return;
        end
        e = peaks_due.pop_front();
        if (w !== e.weight)
        begin
            $display("%0t: peak_weight expected %0d actual %0d", t, e.weight, w);
            errors++;
        end
        if (r !== e.radius)
        begin
            $display("%0t: peak_radius expected %0d actual %0d", t, e.radius, r);
            errors++;
        end
        if (d !== e.dropped)
        begin
            $display("%0t: points_dropped expected %0d actual %0d", t, e.dropped, d);
            errors++;
        end
    endfunction
endclass

module tb_top;
    import scrv_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         op;
    logic signed [23:0] coord_x;
    logic signed [23:0] coord_y;
    logic signed [23:0] coord_z;
    logic               out_valid;
    logic               out_stall;
    logic [20:0]        peak_weight;
    logic [23:0]        peak_radius;
    logic               points_dropped;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [23:0]        cfg_data;

    vote_scoreboard sb;
    bit             quiet;
    int             stall_left;

    sphere_center_radius_vote dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .peak_weight(peak_weight), .peak_radius(peak_radius),
        .points_dropped(points_dropped),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // input and output transactions
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_input(op, coord_x, coord_y, coord_z);
        if (rst_n && out_valid && !out_stall)
            sb.check_result(peak_weight, peak_radius, points_dropped, $time);
    end

    // receiver stall bursts
    always @(negedge clk)
    begin
        if (quiet)
            out_stall = 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall = 1'b1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 17) - 1;
            out_stall = 1'b1;
        end
        else
            out_stall = 1'b0;
    end

    // called at a falling edge, returns at a falling edge with valid still up
    task automatic send_item(input logic [1:0] o, input logic [23:0] x,
                             input logic [23:0] y, input logic [23:0] z);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        in_valid = 1'b1;
        op = o;
        coord_x = x;
        coord_y = y;
        coord_z = z;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid = 1'b0;
        while (sb.peaks_due.size() != 0)
            @(posedge clk);
        // loads and clears give no result
        repeat (10) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [23:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [23:0] near(logic [23:0] c, int spread);
        return c + 24'($urandom_range(0, 2 * spread)) - 24'(spread);
    endfunction

    task automatic random_phase();
        logic [23:0] cx;
        logic [23:0] cy;
        logic [23:0] cz;
        int          spread;
        int          npts;
        int          sel;
        wait_idle();
        sel = $urandom_range(0, 5);
        write_cfg(REG_BIN_COUNT, (sel == 0) ? 24'd127 : (sel == 1) ? 24'd1
                                 : 24'($urandom_range(2, 64)));
        sel = $urandom_range(0, 7);
        write_cfg(REG_SCALE, (sel == 0) ? 24'hFFFFFF : (sel == 1) ? 24'd1
                             : 24'($urandom_range(4096, 1 << 20)));
        sel = $urandom_range(0, 5);
        write_cfg(REG_BIN_WIDTH, (sel == 0) ? 24'hFFFFFF : (sel == 1) ? 24'd1
                                 : 24'($urandom));
        cx = 24'($urandom);
        cy = 24'($urandom);
        cz = 24'($urandom);
        spread = 1 << $urandom_range(6, 14);
        npts = $urandom_range(0, 14);
        if ($urandom_range(0, 3) != 0)
            send_item(OP_CLEAR, 24'($urandom), 24'($urandom), 24'($urandom));
        for (int i = 0; i < npts; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_item(OP_RESERVED, 24'($urandom), 24'($urandom), 24'($urandom));
            send_item(OP_LOAD, near(cx, spread), near(cy, spread), near(cz, spread));
        end
        repeat ($urandom_range(1, 3))
            send_item(OP_QUERY, near(cx, spread / 8), near(cy, spread / 8),
                      near(cz, spread / 8));
    endtask

    initial
    begin
        #(8 * 3000000);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        sb = new();
        quiet = 1'b0;
        stall_left = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = OP_LOAD;
        coord_x = '0;
        coord_y = '0;
        coord_z = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_BIN_COUNT;
        cfg_data = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty store, reset settings
        send_item(OP_QUERY, 24'h0, 24'h0, 24'h0);
        send_item(OP_LOAD, 24'h800000, 24'h800000, 24'h800000);
        send_item(OP_LOAD, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        send_item(OP_LOAD, 24'h000300, 24'h000000, 24'h000000);
        send_item(OP_LOAD, 24'h000180, 24'hFFFF00, 24'h000080);
        send_item(OP_QUERY, 24'h000000, 24'h000000, 24'h000000);
        send_item(OP_QUERY, 24'h800000, 24'h7FFFFF, 24'h800000);
        send_item(OP_RESERVED, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_item(OP_QUERY, 24'h000100, 24'h000100, 24'h000100);
        // no bins in use
        wait_idle();
        write_cfg(REG_BIN_COUNT, 24'd0);
        send_item(OP_QUERY, 24'h000000, 24'h000000, 24'h000000);
        // scale zero sends every vote to bin zero
        wait_idle();
        write_cfg(REG_BIN_COUNT, 24'd127);
        write_cfg(REG_SCALE, 24'd0);
        write_cfg(REG_BIN_WIDTH, 24'hFFFFFF);
        send_item(OP_QUERY, 24'h000000, 24'h000000, 24'h000000);
        wait_idle();
        write_cfg(REG_SCALE, 24'hFFFFFF);
        send_item(OP_QUERY, 24'h000010, 24'h000000, 24'h000000);
        // tie between bins: one point splits its vote equally between bins 1 and 2
        send_item(OP_CLEAR, 24'h0, 24'h0, 24'h0);
        send_item(OP_QUERY, 24'h0, 24'h0, 24'h0);
        wait_idle();
        write_cfg(REG_SCALE, 24'd65536);
        write_cfg(REG_BIN_WIDTH, 24'd65536);
        send_item(OP_LOAD, 24'h000180, 24'h0, 24'h0);
        send_item(OP_LOAD, 24'h000400, 24'h0, 24'h0);
        send_item(OP_QUERY, 24'h0, 24'h0, 24'h0);

        for (int ph = 0; ph < 14; ph++)
            random_phase();

        // cleared store with all bins in use
        wait_idle();
        write_cfg(REG_BIN_COUNT, 24'd64);
        write_cfg(REG_SCALE, 24'd65536);
        send_item(OP_CLEAR, 24'h0, 24'h0, 24'h0);
        send_item(OP_QUERY, 24'h0, 24'h0, 24'h0);
        send_item(OP_CLEAR, 24'h0, 24'h0, 24'h0);
        send_item(OP_QUERY, 24'h0, 24'h0, 24'h0);

        quiet = 1'b1;
        for (int ph = 0; ph < 4; ph++)
            random_phase();

        wait_idle();
        repeat (50) @(posedge clk);
        if (sb.errors == 0 && sb.peaks_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
